FILE: rtl/text_console_writer_assert.svh
// Assertion macros for the text console writer RTL, used by the sequencer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw assertion failed");

// Expression must never be true outside reset.
`define TCW_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tcw forbidden condition");

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned RIDX_W      = 11;
  localparam int unsigned COL_W       = 7;
  localparam int unsigned ROW_W       = 5;
  localparam int unsigned OFF_W       = 11;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned S_TDATA_W   = 24;
  localparam int unsigned M_TDATA_W   = 40;
  localparam int unsigned M_PAD_W     = M_TDATA_W - COL_W - ROW_W - OFF_W - VAL_W;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_ATTR = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [CFG_DATA_W-1:0] TEXT_ATTR_RST  = 8'h0F;
  localparam logic [CFG_DATA_W-1:0] BLANK_ATTR_RST = 8'h07;
  localparam logic [VAL_W-1:0]      RESET_BLANK    = 16'h0720;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef struct packed {
    logic load_item;
    logic clr_start;
    logic clr_step;
    logic fill_reset;
    logic home;
    logic wrap;
    logic scroll_start;
    logic copy_rd;
    logic blank_start;
    logic blank_step;
    logic newline;
    logic store;
    logic tab_inc;
    logic capture;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic is_tab;
    logic need_scroll;
    logic cnt_last;
    logic tab_last;
    logic out_free;
  } tcw_status_t;

endpackage

FILE: rtl/tcw_ctrl.sv
// Sequencer of the text console writer: handshake, sweeps, put steps and reads.
`include "text_console_writer_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic [MODE_W-1:0] s_mode_i,
  output logic              s_tready_o,
  input  tcw_status_t       st_i,
  output tcw_cmd_t          cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_WRAP  = 9'b000000100,
    S_COPY  = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_BLANK = 9'b000100000,
    S_ACT   = 9'b001000000,
    S_READ  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   init_q, init_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    init_d           = init_q;
    cmd_o            = '0;
    cmd_o.fill_reset = init_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_item = 1'b1;
          unique case (mode_e'(s_mode_i))
            MODE_PUT:   state_d = S_WRAP;
            MODE_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLEAR;
            end
            MODE_READ:  state_d = S_READ;
            MODE_NOP:   state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.cnt_last) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            cmd_o.home = 1'b1;
            state_d    = S_RESP;
          end
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        if (st_i.need_scroll) begin
          cmd_o.scroll_start = 1'b1;
          state_d            = S_COPY;
        end else begin
          state_d = S_ACT;
        end
      end
      S_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last copy beat retires here
        cmd_o.blank_start = 1'b1;
        state_d           = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.blank_step = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (st_i.is_newline) begin
          cmd_o.newline = 1'b1;
          state_d       = S_RESP;
        end else if (st_i.is_tab) begin
          cmd_o.store   = 1'b1;
          cmd_o.tab_inc = 1'b1;
          state_d       = st_i.tab_last ? S_RESP : S_WRAP;
        end else begin
          cmd_o.store = 1'b1;
          state_d     = S_RESP;
        end
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  `TCW_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_o.out_load |-> st_i.out_free)
  `TCW_ASSERT(a_put_to_wrap, clk_i, rst_ni, (s_tvalid_i && s_tready_o && s_mode_i == MODE_PUT) |=> state_q == S_WRAP)
  `TCW_ASSERT(a_copy_to_drain, clk_i, rst_ni, (state_q == S_COPY && st_i.cnt_last) |=> state_q == S_DRAIN)
  `TCW_NEVER(a_ready_in_init, clk_i, rst_ni, init_q && s_tready_o)

endmodule

FILE: rtl/tcw_dp.sv
// Datapath of the text console writer: cell store, cursor, sweep counter, result register.
module tcw_dp import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [CHAR_W-1:0]      s_char_i,
  input  logic [RIDX_W-1:0]      s_ridx_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [M_TDATA_W-1:0]   m_tdata_o,
  input  tcw_cmd_t               cmd_i,
  output tcw_status_t            st_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned OW    = $clog2(CELLS + 1);
  localparam int unsigned TW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int unsigned CMPW  = (OW > RIDX_W) ? OW : RIDX_W;

  logic [CFG_DATA_W-1:0] text_attr_q, blank_attr_q;
  logic [CW-1:0]         col_q, col_d;
  logic [RW-1:0]         row_q, row_d;
  logic [AW-1:0]         cnt_q, cnt_d;
  logic                  pend_q;
  logic [AW-1:0]         pend_addr_q;
  logic [CHAR_W-1:0]     char_q;
  logic [RIDX_W-1:0]     ridx_q;
  logic [TW-1:0]         tab_q;
  logic [VAL_W-1:0]      val_q;

  logic [VAL_W-1:0]      mem [CELLS];
  logic [VAL_W-1:0]      rdata_q;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [VAL_W-1:0]      wdata, fill;

  logic [OW-1:0]         off;
  logic                  col_wrap;
  logic [RW:0]           row_w;
  logic                  in_range;

  logic                  m_tvalid_q;
  logic [COL_W-1:0]      out_col_q;
  logic [ROW_W-1:0]      out_row_q;
  logic [OFF_W-1:0]      out_off_q;
  logic [VAL_W-1:0]      out_val_q;

  assign off      = OW'(row_q) * OW'(COLUMNS) + OW'(col_q);
  assign col_wrap = (col_q >= CW'(COLUMNS));
  assign row_w    = {1'b0, row_q} + (RW + 1)'(col_wrap);
  assign in_range = (CMPW'(ridx_q) < CMPW'(CELLS));

  assign st_o.is_newline  = (char_q == CHAR_LF) || (char_q == CHAR_CR);
  assign st_o.is_tab      = (char_q == CHAR_TAB);
  assign st_o.need_scroll = (row_w >= (RW + 1)'(ROWS));
  assign st_o.cnt_last    = (cnt_q == AW'(CELLS - 1));
  assign st_o.tab_last    = (tab_q == TW'(TAB_WIDTH - 1));
  assign st_o.out_free    = !m_tvalid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEXT_ATTR:  text_attr_q  <= cfg_wdata_i;
        CFG_BLANK_ATTR: blank_attr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cursor moves
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.home) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.wrap) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end
    end else if (cmd_i.blank_start) begin
      if (row_q != '0) begin
        row_d = row_q - 1'b1;
      end
    end else if (cmd_i.newline) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else if (cmd_i.store) begin
      col_d = col_q + 1'b1;
    end
  end

  // sweep pointer shared by clear, row copy and last-row blanking
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_start) begin
      cnt_d = '0;
    end else if (cmd_i.scroll_start) begin
      cnt_d = AW'(COLUMNS);
    end else if (cmd_i.blank_start) begin
      cnt_d = AW'(CELLS - COLUMNS);
    end else if (cmd_i.clr_step || cmd_i.copy_rd || cmd_i.blank_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
      tab_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      cnt_q  <= cnt_d;
      pend_q <= cmd_i.copy_rd;
      if (cmd_i.load_item) begin
        tab_q <= '0;
      end else if (cmd_i.tab_inc) begin
        tab_q <= tab_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= cnt_q - AW'(COLUMNS);
    if (cmd_i.load_item) begin
      char_q <= s_char_i;
      ridx_q <= s_ridx_i;
      val_q  <= '0;
    end else if (cmd_i.capture) begin
      val_q <= in_range ? rdata_q : '0;
    end
  end

  assign fill  = cmd_i.fill_reset ? RESET_BLANK : {blank_attr_q, CHAR_SPACE};
  assign raddr = cmd_i.copy_rd ? cnt_q : AW'(s_ridx_i);

  // a pending copy beat owns the write port
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = fill;
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.clr_step) begin
      we = 1'b1;
    end else if (cmd_i.blank_step) begin
      we    = 1'b1;
      wdata = {blank_attr_q, CHAR_SPACE};
    end else if (cmd_i.store) begin
      we    = 1'b1;
      waddr = AW'(off);
      wdata = {text_attr_q, st_o.is_tab ? CHAR_SPACE : char_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_col_q <= COL_W'(col_q);
      out_row_q <= ROW_W'(row_q);
      out_off_q <= OFF_W'(off);
      out_val_q <= val_q;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {{M_PAD_W{1'b0}}, out_val_q, out_off_q, out_row_q, out_col_q};

endmodule

FILE: rtl/text_console_writer.sv
// Put char: wrap check, store, result load; a tab does TAB_WIDTH wrap-and-store steps.
// A scroll copies the rows up, then blanks the last row, one cell copy per cycle through
// the store's port pair. Clear writes one cell per cycle; a new item is taken only when idle.
// The result register frees the input side while a result waits to be taken.
// After reset a clearing pass writes 0x0720 to all ROWS*COLUMNS cells, one a cycle, with
// tready low; attribute registers reset to 0x0F and 0x07, the cursor to row 0, column 0.
module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mode[1:0], char_code[9:2], read_index[20:10], zero pad
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cursor_column[6:0], cursor_row[11:7], cursor_offset[22:12], cell_value[38:23], zero pad
  output logic [M_TDATA_W-1:0]   m_axis_tdata
);

  tcw_cmd_t    cmd;
  tcw_status_t st;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_mode_i   (s_axis_tdata[MODE_W-1:0]),
    .s_tready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tcw_dp #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_char_i    (s_axis_tdata[MODE_W +: CHAR_W]),
    .s_ridx_i    (s_axis_tdata[MODE_W + CHAR_W +: RIDX_W]),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

FILE: sim/text_console_writer_test.sv
// Self-checking testbench for the text console writer: cursor, wrap, scroll, clear and reads.
module text_console_writer_test;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int PHASES    = 5;
  localparam int RANDOM_PER_PHASE = 150;

  typedef struct packed {
    logic [RIDX_W-1:0] ridx;
    logic [CHAR_W-1:0] ch;
    mode_e             mode;
  } console_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] cell_val;
    logic [OFF_W-1:0] off;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cursor_report_t;

  // Screen and cursor mirror plus the queue of cursor reports still owed by the block.
  class console_tracker;
    logic [VAL_W-1:0] cells [CELLS];
    int col;
    int row;
    logic [CFG_DATA_W-1:0] text_attr;
    logic [CFG_DATA_W-1:0] blank_attr;
    cursor_report_t owed_reports [$];
    int failures;
    int shown;
    int checked;
    int glyphs;
    int scrolls;
    int wraps;
    int clears;
    int reads;

    function new();
      foreach (cells[i]) cells[i] = RESET_BLANK;
      col = 0;
      row = 0;
      text_attr = TEXT_ATTR_RST;
      blank_attr = BLANK_ATTR_RST;
    endfunction

    function int cursor_offset();
      return row * COLUMNS + col;
    endfunction

    function int owed();
      return owed_reports.size();
    endfunction

    function void blank_range(int from, int upto);
      for (int i = from; i < upto && i < CELLS; i++) cells[i] = {blank_attr, CHAR_SPACE};
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      blank_range(CELLS - COLUMNS, CELLS);
      if (row > 0) row--;
      scrolls++;
    endfunction

    // Offset is taken before the wrap; it alone decides how many rows scroll.
    function void wrap_and_scroll();
      int off;
      off = cursor_offset();
      if (col >= COLUMNS) begin
        col = 0;
        row++;
        wraps++;
      end
      if (off >= CELLS) begin
        repeat ((off - CELLS) / COLUMNS + 1) scroll_up();
      end
    endfunction

    function void store_glyph(logic [CHAR_W-1:0] c);
      int idx;
      idx = cursor_offset();
      if (idx < CELLS) cells[idx] = {text_attr, c};
      col++;
      glyphs++;
    endfunction

    function void note_command(console_cmd_t cmd);
      cursor_report_t rep;
      rep.cell_val = '0;
      case (cmd.mode)
        MODE_PUT: begin
          wrap_and_scroll();
          if (cmd.ch == CHAR_LF || cmd.ch == CHAR_CR) begin
            col = 0;
            row++;
          end else if (cmd.ch == CHAR_TAB) begin
            repeat (TAB_WIDTH) begin
              wrap_and_scroll();
              store_glyph(CHAR_SPACE);
            end
          end else begin
            store_glyph(cmd.ch);
          end
        end
        MODE_CLEAR: begin
          blank_range(0, CELLS);
          col = 0;
          row = 0;
          clears++;
        end
        MODE_READ: begin
          if (cmd.ridx < CELLS) rep.cell_val = cells[cmd.ridx];
          reads++;
        end
        default: ;
      endcase
      rep.col = COL_W'(col);
      rep.row = ROW_W'(row);
      rep.off = OFF_W'(cursor_offset());
      owed_reports.push_back(rep);
    endfunction

    function void check_report(logic [M_TDATA_W-1:0] beat);
      cursor_report_t got;
      cursor_report_t want;
      got.col      = beat[0 +: COL_W];
      got.row      = beat[COL_W +: ROW_W];
      got.off      = beat[COL_W + ROW_W +: OFF_W];
      got.cell_val = beat[COL_W + ROW_W + OFF_W +: VAL_W];
      checked++;
      if (owed_reports.size() == 0) begin
        failures++;
        if (shown < 10)
          $display("unexpected result beat: col %0d row %0d off %0d cell %h",
                   got.col, got.row, got.off, got.cell_val);
        shown++;
        return;
      end
      want = owed_reports.pop_front();
      if (got.col != want.col || got.row != want.row || got.off != want.off ||
          got.cell_val != want.cell_val) begin
        failures++;
        if (shown < 10)
          $display({"result %0d mismatch: expected col %0d row %0d off %0d cell %h,",
                    " got col %0d row %0d off %0d cell %h"},
                   checked, want.col, want.row, want.off, want.cell_val,
                   got.col, got.row, got.off, got.cell_val);
        shown++;
      end
    endfunction

    function void close_out();
      if (owed_reports.size() != 0) begin
        $display("%0d result beats never arrived", owed_reports.size());
        failures += owed_reports.size();
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // mode[1:0], char_code[9:2], read_index[20:10], zero pad
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // cursor_column[6:0], cursor_row[11:7], cursor_offset[22:12], cell_value[38:23], zero pad
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  console_tracker tracker = new();
  bit no_idle = 1'b0;
  int text_run = 0;
  int lf_run = 0;

  text_console_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("FAIL text_console_writer");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 2) != 0) return 0;
    return idle_len();
  endfunction

  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
  end

  function automatic console_cmd_t cmd_of(mode_e m, int ch, int ridx);
    console_cmd_t c;
    c.mode = m;
    c.ch = CHAR_W'(ch);
    c.ridx = RIDX_W'(ridx);
    return c;
  endfunction

  // Mostly printable text with newlines, runs of long lines and newline bursts to push
  // the cursor into wrap and scroll; some reads aim near the cursor to see recent writes.
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int r;
    int back;
    c.mode = MODE_PUT;
    c.ch = CHAR_W'($urandom_range(0, 255));
    c.ridx = RIDX_W'($urandom_range(0, 2047));
    if (lf_run > 0) begin
      lf_run--;
      c.ch = CHAR_LF;
      return c;
    end
    if (text_run > 0) begin
      text_run--;
      c.ch = CHAR_W'($urandom_range(32, 126));
      return c;
    end
    r = $urandom_range(0, 999);
    if (r < 3) begin
      c.mode = MODE_CLEAR;
    end else if (r < 20) begin
      c.mode = MODE_NOP;
    end else if (r < 110) begin
      c.mode = MODE_READ;
      if (r < 65) begin
        back = $urandom_range(1, 160);
        c.ridx = RIDX_W'((tracker.cursor_offset() + CELLS - back) % CELLS);
      end else if (r < 100) begin
        c.ridx = RIDX_W'($urandom_range(0, CELLS - 1));
      end else begin
        c.ridx = RIDX_W'($urandom_range(CELLS, 2047));
      end
    end else if (r < 130) begin
      text_run = $urandom_range(60, 170);
      c.ch = CHAR_W'($urandom_range(32, 126));
    end else if (r < 145) begin
      lf_run = $urandom_range(4, 30);
      c.ch = CHAR_LF;
    end else if (r < 230) begin
      c.ch = CHAR_LF;
    end else if (r < 260) begin
      c.ch = CHAR_CR;
    end else if (r < 300) begin
      c.ch = CHAR_TAB;
    end else if (r >= 340) begin
      c.ch = CHAR_W'($urandom_range(32, 126));
    end
    return c;
  endfunction

  task automatic send_cmd(input console_cmd_t cmd);
    int gap;
    gap = sender_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(cmd);
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_command(cmd);
  endtask

  // Hold the input side until every owed result is back and the block takes beats again.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_attrs(input logic [CFG_DATA_W-1:0] text, input logic [CFG_DATA_W-1:0] blank);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TEXT_ATTR;
    cfg_wdata_i <= text;
    @(negedge clk_i);
    cfg_index_i <= CFG_BLANK_ATTR;
    cfg_wdata_i <= blank;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.text_attr = text;
    tracker.blank_attr = blank;
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] text;
    logic [CFG_DATA_W-1:0] blank;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_TEXT_ATTR;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin text = TEXT_ATTR_RST; blank = BLANK_ATTR_RST; end
        1: begin text = 8'hFF; blank = 8'h00; end
        2: begin text = 8'h00; blank = 8'hFF; end
        default: begin
          text = CFG_DATA_W'($urandom_range(0, 255));
          blank = CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      wait_idle();
      write_attrs(text, blank);

      if (ph == 0) begin
        // Fresh screen, out-of-range reads, unused mode, control characters.
        send_cmd(cmd_of(MODE_READ, 8'hFF, 0));
        send_cmd(cmd_of(MODE_READ, 8'h00, CELLS - 1));
        send_cmd(cmd_of(MODE_READ, 8'h00, CELLS));
        send_cmd(cmd_of(MODE_READ, 8'h00, 2047));
        send_cmd(cmd_of(MODE_NOP, 8'hFF, 2047));
        send_cmd(cmd_of(MODE_PUT, 8'h48, 0));
        send_cmd(cmd_of(MODE_PUT, 8'h00, 2047));
        send_cmd(cmd_of(MODE_PUT, 8'hFF, 0));
        send_cmd(cmd_of(MODE_PUT, CHAR_TAB, 0));
        send_cmd(cmd_of(MODE_READ, 8'h00, 1));
        send_cmd(cmd_of(MODE_READ, 8'h00, 2));
        send_cmd(cmd_of(MODE_READ, 8'h00, 5));
        send_cmd(cmd_of(MODE_PUT, CHAR_LF, 0));
        send_cmd(cmd_of(MODE_PUT, 8'h78, 0));
        send_cmd(cmd_of(MODE_PUT, CHAR_CR, 0));
        send_cmd(cmd_of(MODE_READ, 8'h00, COLUMNS));
        send_cmd(cmd_of(MODE_NOP, 8'h00, 0));
        send_cmd(cmd_of(MODE_CLEAR, 8'h41, 3));
        send_cmd(cmd_of(MODE_READ, 8'h00, 0));
        send_cmd(cmd_of(MODE_PUT, CHAR_TAB, 0));
      end else if (ph % 2 == 0) begin
        send_cmd(cmd_of(MODE_CLEAR, 0, 0));
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_cmd(random_cmd());
      end
    end

    wait_idle();
    no_idle = 1'b1;
    repeat (50) @(posedge clk_i);
    tracker.close_out();
    $display("checked %0d result beats: %0d glyphs stored, %0d wraps, %0d scrolls",
             tracker.checked, tracker.glyphs, tracker.wraps, tracker.scrolls);
    $display("%0d clears, %0d cell reads over %0d attribute settings",
             tracker.clears, tracker.reads, PHASES);
    if (tracker.failures == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
sim/text_console_writer_test.sv
